@@ hdl/bc1e_pkg.sv @@
// Shared types, constants and arithmetic helpers for the BC1 tile encoder.
// Used by the pixel chain cell, the distance unit, the top level and the checker.
// Depends on nothing.
package bc1e_pkg;

  // Tile geometry and widths.
  localparam int TilePixels = 16;
  localparam int CountW     = $clog2(TilePixels);
  localparam int PalEntries = 4;
  localparam int SelW       = $clog2(PalEntries);
  localparam int DistW      = 18;
  localparam int IndexW     = SelW * TilePixels;

  // Reciprocal of three in Q11; exact for the numerators that occur here.
  localparam logic [10:0] RecipThree = 11'd683;

  // Palette entry codes.
  localparam logic [SelW-1:0] SelMax   = 2'd0;
  localparam logic [SelW-1:0] SelMin   = 2'd1;
  localparam logic [SelW-1:0] SelNearA = 2'd2;
  localparam logic [SelW-1:0] SelNearB = 2'd3;

  // One RGB pixel, eight bits per channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef pixel_t [PalEntries-1:0] palette_t;
  typedef logic [DistW-1:0] dist_t;
  typedef dist_t [PalEntries-1:0] dist_set_t;

  // Packs an 8-bit colour into RGB565.
  function automatic logic [15:0] pack565(input pixel_t c);
    pack565 = {c.red[7:3], c.green[7:2], c.blue[7:3]};
  endfunction

  // Divides a numerator of at most 765 by three, truncating.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = {11'd0, x} * {10'd0, RecipThree};
    div3 = prod[18:11];
  endfunction

  // Squared difference of two channel values.
  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    sq_diff = {8'd0, d} * {8'd0, d};
  endfunction

endpackage

@@ hdl/bc1e_cell.sv @@
// One cell of the pixel chain: holds one stored pixel and hands it on.
// Depends on bc1e_pkg for the pixel type.
module bc1e_cell
  import bc1e_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  pixel_t pix_i,
  output pixel_t pix_o
);

  pixel_t pix_q;

  // Take the neighbour's pixel whenever the chain moves.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pix_q <= pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

@@ hdl/bc1e_dist.sv @@
// Distance unit: squared distance from one pixel to each of the four palette entries.
// Registered result. Depends on bc1e_pkg.
module bc1e_dist
  import bc1e_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  pixel_t    pix_i,
  input  palette_t  pal_i,
  output logic      valid_o,
  output dist_set_t dist_o
);

  logic      valid_q;
  dist_set_t dist_d, dist_q;

  // Sum of the three channel squares for each entry.
  always_comb begin
    for (int j = 0; j < PalEntries; j++) begin
      dist_d[j] = DistW'(sq_diff(pix_i.red,   pal_i[j].red))
                + DistW'(sq_diff(pix_i.green, pal_i[j].green))
                + DistW'(sq_diff(pix_i.blue,  pal_i[j].blue));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dist_q <= dist_d;
    end
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;

endmodule

@@ hdl/bc1_texture_block_encoder_unit.sv @@
// BC1 tile encoder top level: pixel chain, endpoint logic, index accumulation.
// Depends on bc1e_pkg, bc1e_cell and bc1e_dist.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, red_i, green_i, blue_i) takes the
//   sixteen pixels of a 4x4 tile in raster order, one transfer per cycle while not
//   stalled. Each pixel enters a chain of sixteen cells while the channel minima and
//   maxima are tracked. After the sixteenth pixel the StCalc state forms the endpoints
//   and the palette, then the chain shifts its pixels past the distance unit one per
//   cycle. The StDrain and StOut states finish the last index and load the block into
//   the output register, which presents it on the output channel (out_valid_o,
//   out_stall_i, color_zero_o, color_one_o, index_bits_o). Tile throughput is set by
//   the single distance unit at the end of the chain, which sees one stored pixel per
//   cycle. in_stall_o is high from the sixteenth pixel until the block has been
//   written to the output register.
//   The output register holds a finished block while the receiver stalls, and the
//   next tile may load meanwhile; a second block waits until the first is taken.
//   Reset empties the tile, clears the maxima to zero and sets the minima to all ones.
module bc1_texture_block_encoder_unit
  import bc1e_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       color_zero_o,
  output logic [15:0]       color_one_o,
  output logic [IndexW-1:0] index_bits_o
);

  typedef enum logic [4:0] {
    StLoad  = 5'b00001,
    StCalc  = 5'b00010,
    StClass = 5'b00100,
    StDrain = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  pixel_t              lo_q, lo_d, hi_q, hi_d;
  logic [15:0]         ep0_q, ep0_d, ep1_q, ep1_d;
  palette_t            pal_q, pal_d;
  logic [IndexW-1:0]   acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_c0_q, out_c1_q;
  logic [IndexW-1:0]   out_idx_q;

  logic                in_xfer, out_free, shift, load_out;
  pixel_t              in_pix, head_pix;
  pixel_t [TilePixels-1:0] chain;
  logic                dist_valid;
  dist_set_t           pal_dist;
  logic [SelW-1:0]     sel;
  dist_t               best;

  assign in_pix   = '{red: red_i, green: green_i, blue: blue_i};
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign shift    = in_xfer || (state_q == StClass);
  assign load_out = (state_q == StOut) && out_free;

  // Chain of pixel cells; the oldest pixel sits at the far end.
  for (genvar k = 0; k < TilePixels; k++) begin : g_chain
    bc1e_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .pix_i  ((k == 0) ? in_pix : chain[(k == 0) ? 0 : k-1]),
      .pix_o  (chain[k])
    );
  end
  assign head_pix = chain[TilePixels-1];

  bc1e_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(state_q == StClass),
    .pix_i  (head_pix),
    .pal_i  (pal_q),
    .valid_o(dist_valid),
    .dist_o (pal_dist)
  );

  // Nearest palette entry; ties keep the lower index.
  always_comb begin
    sel  = SelMax;
    best = pal_dist[SelMax];
    if (pal_dist[SelMin] < best) begin
      sel  = SelMin;
      best = pal_dist[SelMin];
    end
    if (pal_dist[SelNearA] < best) begin
      sel  = SelNearA;
      best = pal_dist[SelNearA];
    end
    if (pal_dist[SelNearB] < best) begin
      sel = SelNearB;
    end
  end

  // Sequencer, extremes, endpoints and palette.
  always_comb begin
    pixel_t      mx, mn;
    logic [15:0] c0, c1;
    state_d = state_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ep0_d   = ep0_q;
    ep1_d   = ep1_q;
    pal_d   = pal_q;
    mx      = hi_q;
    mn      = lo_q;
    c0      = pack565(hi_q);
    c1      = pack565(lo_q);

    unique case (state_q)
      StLoad: begin
        if (in_xfer) begin
          lo_d.red   = (in_pix.red   < lo_q.red)   ? in_pix.red   : lo_q.red;
          lo_d.green = (in_pix.green < lo_q.green) ? in_pix.green : lo_q.green;
          lo_d.blue  = (in_pix.blue  < lo_q.blue)  ? in_pix.blue  : lo_q.blue;
          hi_d.red   = (in_pix.red   > hi_q.red)   ? in_pix.red   : hi_q.red;
          hi_d.green = (in_pix.green > hi_q.green) ? in_pix.green : hi_q.green;
          hi_d.blue  = (in_pix.blue  > hi_q.blue)  ? in_pix.blue  : hi_q.blue;
          cnt_d      = cnt_q + 1'b1;
          if (cnt_q == CountW'(TilePixels - 1)) begin
            state_d = StCalc;
          end
        end
      end
      StCalc: begin
        // The swap cannot fire while max >= min per channel, but is kept.
        if (c0 < c1) begin
          mx = lo_q;
          mn = hi_q;
          ep0_d = c1;
          ep1_d = c0;
        end else if (c0 == c1) begin
          if (c0 != 16'd0) begin
            ep0_d = c0;
            ep1_d = c0 - 16'd1;
          end else begin
            ep0_d = 16'd1;
            ep1_d = c1;
          end
        end else begin
          ep0_d = c0;
          ep1_d = c1;
        end
        pal_d[SelMax]         = mx;
        pal_d[SelMin]         = mn;
        pal_d[SelNearA].red   = div3({1'b0, mx.red, 1'b0}   + {2'd0, mn.red});
        pal_d[SelNearA].green = div3({1'b0, mx.green, 1'b0} + {2'd0, mn.green});
        pal_d[SelNearA].blue  = div3({1'b0, mx.blue, 1'b0}  + {2'd0, mn.blue});
        pal_d[SelNearB].red   = div3({2'd0, mx.red}   + {1'b0, mn.red, 1'b0});
        pal_d[SelNearB].green = div3({2'd0, mx.green} + {1'b0, mn.green, 1'b0});
        pal_d[SelNearB].blue  = div3({2'd0, mx.blue}  + {1'b0, mn.blue, 1'b0});
        lo_d    = '1;
        hi_d    = '0;
        cnt_d   = '0;
        state_d = StClass;
      end
      StClass: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CountW'(TilePixels - 1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          state_d = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Index accumulator: new index enters at the top, pixel 0 ends at the bottom.
  always_comb begin
    acc_d = acc_q;
    if (dist_valid) begin
      acc_d = {sel, acc_q[IndexW-1:SelW]};
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      lo_q        <= '1;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ep0_q <= ep0_d;
    ep1_q <= ep1_d;
    pal_q <= pal_d;
    acc_q <= acc_d;
    if (load_out) begin
      out_c0_q  <= ep0_q;
      out_c1_q  <= ep1_q;
      out_idx_q <= acc_q;
    end
  end

  assign in_stall_o   = (state_q != StLoad);
  assign out_valid_o  = out_valid_q;
  assign color_zero_o = out_c0_q;
  assign color_one_o  = out_c1_q;
  assign index_bits_o = out_idx_q;

endmodule

@@ hdl/bc1e_checker.sv @@
// Port-level checker for the BC1 tile encoder, bound to the top level.
// Depends on bc1e_pkg for the index width.
module bc1e_checker
  import bc1e_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [15:0]       color_zero_o,
  input logic [15:0]       color_one_o,
  input logic [IndexW-1:0] index_bits_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(color_zero_o) && $stable(color_one_o)
      && $stable(index_bits_o))
    else $error("result payload changed while stalled");

  // Endpoint ordering and adjustment always leave color_zero above color_one.
  a_endpoint_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> color_zero_o > color_one_o)
    else $error("endpoints not strictly ordered");

  // When a block appears the encoder is already open for the next tile.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("input still stalled when a block is presented");

endmodule

bind bc1_texture_block_encoder_unit bc1e_checker u_checker (.*);
